>>> hdl/ppm_pkg.sv
// Shared types, widths and opcodes for the polynomial multiplier.
package ppm_pkg;

  localparam int COEF_W      = 10;
  localparam int OP_W        = 2;
  localparam int VALUE_W     = 10;
  localparam int IDX_W       = 6;
  localparam int MAX_LEN_DEF = 32;
  localparam int MODULUS_DEF = 1009;
  localparam int SUM_W_DEF   = 2 * COEF_W + $clog2(MAX_LEN_DEF);

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [COEF_W-1:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] product_value;
    logic [IDX_W-1:0]   product_index;
    logic               last;
  } out_item_t;

  // Broadcast control for the cell chain
  typedef struct packed {
    logic              clear;
    logic              step;
    logic [COEF_W-1:0] x;
  } cell_ctrl_t;

endpackage

>>> hdl/ppm_cell.sv
// One convolution cell: holds a coefficient of a and a running partial sum.
module ppm_cell import ppm_pkg::*; #(
  parameter int SUM_W = SUM_W_DEF
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              load_en,
  input  logic [COEF_W-1:0] load_coef,
  input  logic              active,
  input  logic [SUM_W-1:0]  acc_in,
  output logic [SUM_W-1:0]  acc_out
);

  logic [COEF_W-1:0]   coef_r;
  logic [SUM_W-1:0]    acc_r;
  logic [2*COEF_W-1:0] prod;
  logic [SUM_W-1:0]    sum;

  // Multiply the broadcast sample and add the neighbor's partial sum
  assign prod = active ? (coef_r * ctrl.x) : '0;
  assign sum  = acc_in + SUM_W'(prod);

  // Hold the a coefficient once loaded
  always_ff @(posedge clk) begin
    if (load_en) begin
      coef_r <= load_coef;
    end
  end

  // Clear at run start, advance one tap per step
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.step) begin
      acc_r <= sum;
    end
  end

  assign acc_out = acc_r;

endmodule

>>> hdl/ppm_reduce.sv
// Pipelined reciprocal reduction of a convolution sum modulo the prime.
module ppm_reduce import ppm_pkg::*; #(
  parameter int SUM_W   = SUM_W_DEF,
  parameter int MODULUS = MODULUS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] value,
  output logic             done,
  output logic [$clog2(MODULUS+1)-1:0] result
);

  localparam int MOD_W  = $clog2(MODULUS + 1);
  localparam int PROD_W = 2 * SUM_W;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / MODULUS);
  localparam logic [SUM_W-1:0] MOD_V = SUM_W'(MODULUS);

  logic [1:0]       vld_r;
  logic             done_r;
  logic [SUM_W-1:0] val_r;
  logic [SUM_W-1:0] q_r;
  logic [SUM_W-1:0] rem_r;
  logic [MOD_W-1:0] res_r;
  logic [SUM_W-1:0] rem_raw;

  // The reciprocal quotient is exact or one short, so rem_raw stays below twice the modulus
  assign rem_raw = val_r - q_r * MOD_V;

  // Advance the stage valids: quotient, remainder, final correction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      done_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[0], start};
      done_r <= vld_r[1];
    end
  end

  // Estimate the quotient, form the remainder, then subtract the modulus once if needed
  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      q_r   <= SUM_W'((PROD_W'(value) * PROD_W'(RECIP)) >> SUM_W);
    end
    if (vld_r[0]) begin
      rem_r <= rem_raw;
    end
    if (vld_r[1]) begin
      res_r <= (rem_r >= MOD_V) ? MOD_W'(rem_r - MOD_V) : MOD_W'(rem_r);
    end
  end

  assign done   = done_r;
  assign result = res_r;

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (res_r < MOD_W'(MODULUS)))
    else $error("reduced value not below modulus");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (|vld_r) |-> !start)
    else $error("reduction restarted while busy");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 done_r)
    else $error("reduction did not finish in three cycles");

endmodule

>>> hdl/polynomial_multiply_mod_prime.sv
// Polynomial multiplier mod a prime: a transposed systolic chain of cells.
// Loads are taken while idle; the channel is stalled while a compute runs.
// Compute: a clear state, then per product coefficient a chain step, a launch
// of the reduction, a wait for its result and an emit state that holds while
// out_stall is high. With a or b empty, one zero result with last set is emitted.
// Reset clears both lengths and control; coefficient stores stay undefined.
module polynomial_multiply_mod_prime import ppm_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int MODULUS = MODULUS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int T_W   = CNT_W + 1;
  localparam int SUM_W = 2 * COEF_W + $clog2(MAX_LEN);
  localparam int MOD_W = $clog2(MODULUS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_STEP,
    S_LAUNCH,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_a_r;
  logic [CNT_W-1:0]   count_b_r;
  logic [T_W-1:0]     t_r;
  logic [IDX_W-1:0]   idx_r;
  logic               last_r;
  logic               out_valid_r;
  out_item_t          out_r;
  logic [COEF_W-1:0]  rd_data_r;
  logic [COEF_W-1:0]  store_b [MAX_LEN];

  logic               in_fire;
  logic               out_fire;
  logic               load_a;
  logic               load_b;
  logic [T_W-1:0]     total;
  cell_ctrl_t         ctrl;
  logic [SUM_W-1:0]   acc [MAX_LEN+1];
  logic               red_done;
  logic [MOD_W-1:0]   red_result;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign load_a = in_fire && (in_data.opcode == OP_LOAD_A);
  assign load_b = in_fire && (in_data.opcode == OP_LOAD_B) &&
                  (count_b_r < CNT_W'(MAX_LEN));
  assign total  = T_W'(count_a_r) + T_W'(count_b_r) - T_W'(1);

  // Broadcast b while it lasts, then flush zeros through the chain
  always_comb begin
    ctrl.clear = (state_r == S_CLEAR);
    ctrl.step  = (state_r == S_STEP);
    ctrl.x     = (t_r < T_W'(count_b_r)) ? rd_data_r : '0;
  end

  // Store b: write on load, registered read at the step counter
  always_ff @(posedge clk) begin
    if (load_b) begin
      store_b[count_b_r[AW-1:0]] <= in_data.coefficient;
    end
    rd_data_r <= store_b[t_r[AW-1:0]];
  end

  // Chain of cells; cell 0 holds the finished product coefficient
  assign acc[MAX_LEN] = '0;
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    ppm_cell #(
      .SUM_W(SUM_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_en  (load_a && (count_a_r == CNT_W'(i))),
      .load_coef(in_data.coefficient),
      .active   (count_a_r > CNT_W'(i)),
      .acc_in   (acc[i+1]),
      .acc_out  (acc[i])
    );
  end

  ppm_reduce #(
    .SUM_W  (SUM_W),
    .MODULUS(MODULUS)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_LAUNCH),
    .value (acc[0]),
    .done  (red_done),
    .result(red_result)
  );

  // Sequence loads, chain steps, reduction and result transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data.opcode)
              OP_LOAD_A: begin
                if (count_a_r < CNT_W'(MAX_LEN)) begin
                  count_a_r <= count_a_r + CNT_W'(1);
                end
              end
              OP_LOAD_B: begin
                if (count_b_r < CNT_W'(MAX_LEN)) begin
                  count_b_r <= count_b_r + CNT_W'(1);
                end
              end
              OP_COMPUTE: begin
                if (count_a_r == '0 || count_b_r == '0) begin
                  out_r.product_value <= '0;
                  out_r.product_index <= '0;
                  out_r.last          <= 1'b1;
                  out_valid_r         <= 1'b1;
                  state_r             <= S_EMIT;
                end else begin
                  t_r     <= '0;
                  state_r <= S_CLEAR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          state_r <= S_STEP;
        end
        S_STEP: begin
          idx_r   <= IDX_W'(t_r);
          last_r  <= (t_r + T_W'(1) == total);
          t_r     <= t_r + T_W'(1);
          state_r <= S_LAUNCH;
        end
        S_LAUNCH: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (red_done) begin
            out_r.product_value <= VALUE_W'(red_result);
            out_r.product_index <= idx_r;
            out_r.last          <= last_r;
            out_valid_r         <= 1'b1;
            state_r             <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_r.last) begin
              count_a_r <= '0;
              count_b_r <= '0;
              state_r   <= S_IDLE;
            end else begin
              state_r <= S_STEP;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input taken while a result is pending");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_r.last) |=> (count_a_r == '0 && count_b_r == '0))
    else $error("lengths not cleared after final transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CNT_W'(MAX_LEN)) && (count_b_r <= CNT_W'(MAX_LEN)))
    else $error("coefficient count beyond capacity");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (T_W'(out_r.product_index) < total || out_r.product_index == '0))
    else $error("product index beyond product length");

endmodule

>>> dv/polynomial_multiply_mod_prime_tb.sv
// Self-checking testbench for the polynomial multiplier modulo 1009.
module polynomial_multiply_mod_prime_tb;
  import ppm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 320;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;

  // One directed step: an item repeated reps times, with an optional typed-in result
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COEF_W-1:0] coef;
    logic [5:0]        reps;
    logic              typed;
    out_item_t         exp;
  } stim_row_t;

  localparam out_item_t NO_EXP    = '0;
  localparam out_item_t EMPTY_RUN = '{10'd0, 6'd0, 1'b1};
  localparam out_item_t UNIT_RUN  = '{10'd1, 6'd0, 1'b1};

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{OP_COMPUTE, 10'd0,    6'd1,  1'b1, EMPTY_RUN},  // nothing loaded after reset
    '{OP_LOAD_A,  10'd1008, 6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_B,  10'd1008, 6'd1,  1'b0, NO_EXP},
    '{OP_COMPUTE, 10'd0,    6'd1,  1'b1, UNIT_RUN},   // (-1)*(-1) mod p
    '{OP_LOAD_A,  10'd0,    6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_B,  10'd0,    6'd1,  1'b0, NO_EXP},
    '{OP_COMPUTE, 10'd1023, 6'd1,  1'b1, EMPTY_RUN},  // zero product, field ignored
    '{OP_LOAD_A,  10'd5,    6'd1,  1'b0, NO_EXP},
    '{OP_COMPUTE, 10'd0,    6'd1,  1'b1, EMPTY_RUN},  // b empty
    '{OP_LOAD_B,  10'd7,    6'd1,  1'b0, NO_EXP},
    '{OP_COMPUTE, 10'd0,    6'd1,  1'b1, EMPTY_RUN},  // a empty
    '{OP_UNUSED,  10'd1023, 6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_A,  10'd1023, 6'd1,  1'b0, NO_EXP},     // out-of-range coefficients
    '{OP_LOAD_B,  10'd1009, 6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_A,  10'd1,    6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_B,  10'd1023, 6'd1,  1'b0, NO_EXP},
    '{OP_UNUSED,  10'd0,    6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_B,  10'd512,  6'd1,  1'b0, NO_EXP},
    '{OP_COMPUTE, 10'd0,    6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_A,  10'd1008, 6'd33, 1'b0, NO_EXP},     // one load past full on each side
    '{OP_LOAD_B,  10'd1008, 6'd33, 1'b0, NO_EXP},
    '{OP_COMPUTE, 10'd0,    6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_A,  10'd682,  6'd1,  1'b0, NO_EXP},
    '{OP_LOAD_B,  10'd341,  6'd1,  1'b0, NO_EXP},
    '{OP_COMPUTE, 10'd341,  6'd1,  1'b0, NO_EXP}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Side-band travelling with the offered item: typed-in expectation, if any
  logic      cur_typed = 1'b0;
  out_item_t cur_exp = '0;

  logic pressure_req = 1'b0;

  // Mirror of the block state
  logic [COEF_W-1:0] coef_a [MAX_LEN_DEF];
  logic [COEF_W-1:0] coef_b [MAX_LEN_DEF];
  int                len_a = 0;
  int                len_b = 0;

  out_item_t expected_products [$];
  in_item_t  seq_q [$];

  int err_count = 0;
  int in_transfers = 0;
  int out_transfers = 0;
  int runs_done = 0;
  int longest_run = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit sender_quiet = 1'b0;

  polynomial_multiply_mod_prime dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic in_item_t mk(input logic [OP_W-1:0] op, input logic [COEF_W-1:0] c);
    in_item_t it;
    it.opcode      = op;
    it.coefficient = c;
    return it;
  endfunction

  // Append one expected product coefficient to the scoreboard
  function automatic void queue_product(input out_item_t p);
    expected_products.insert(expected_products.size(), p);
  endfunction

  // Append one item to the pending sequence
  function automatic void queue_item(input in_item_t it);
    seq_q.insert(seq_q.size(), it);
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return COEF_W'($urandom_range(1009, 1023));
    if (r == 2) return COEF_W'(0);
    if (r == 3) return COEF_W'(1008);
    return COEF_W'($urandom_range(0, 1008));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 31);
    return $urandom_range(32, 34);
  endfunction

  // Update the mirrored state for one item and, if keep is set, queue the product coefficients
  task automatic apply_item(input in_item_t it, input bit keep);
    int unsigned sum;
    int total, p, i;
    out_item_t r;
    case (it.opcode)
      OP_LOAD_A: begin
        if (len_a < MAX_LEN_DEF) begin
          coef_a[len_a] = it.coefficient;
          len_a++;
        end
      end
      OP_LOAD_B: begin
        if (len_b < MAX_LEN_DEF) begin
          coef_b[len_b] = it.coefficient;
          len_b++;
        end
      end
      OP_COMPUTE: begin
        if (len_a == 0 || len_b == 0) begin
          if (keep) queue_product(EMPTY_RUN);
        end else begin
          total = len_a + len_b - 1;
          for (p = 0; p < total; p++) begin
            sum = 0;
            for (i = 0; i < len_a; i++) begin
              if (p >= i && p - i < len_b)
                sum += 32'(coef_a[i]) * 32'(coef_b[p - i]);
            end
            r.product_value = VALUE_W'(sum % MODULUS_DEF);
            r.product_index = IDX_W'(p);
            r.last          = (p == total - 1);
            if (keep) queue_product(r);
          end
        end
        len_a = 0;
        len_b = 0;
      end
      default: ;
    endcase
  endtask

  // Offer one item, in bursts with random gaps, and hold it until the transfer
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t exp);
    int gap;
    if (burst_left == 0) begin
      gap = sender_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    cur_typed <= typed;
    cur_exp   <= exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Queue loads of a and b, optionally interleaved and mixed with unused opcodes
  task automatic build_operands(input int la, input int lb, input bit mixed, input bit noisy);
    int ra, rb;
    ra = la;
    rb = lb;
    while (ra + rb > 0) begin
      if (noisy && $urandom_range(0, 3) == 0)
        queue_item(mk(OP_UNUSED, rand_coef()));
      if (rb == 0 || (ra > 0 && (!mixed || $urandom_range(0, 1) == 0))) begin
        queue_item(mk(OP_LOAD_A, rand_coef()));
        ra--;
      end else begin
        queue_item(mk(OP_LOAD_B, rand_coef()));
        rb--;
      end
    end
  endtask

  // Predict on every input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      in_transfers++;
      if (cur_typed) begin
        apply_item(in_data, 1'b0);
        queue_product(cur_exp);
      end else begin
        apply_item(in_data, 1'b1);
      end
    end
  end

  // Compare every output transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_transfers++;
      if (out_data.last) begin
        runs_done++;
        if (int'(out_data.product_index) + 1 > longest_run)
          longest_run = int'(out_data.product_index) + 1;
      end
      if (expected_products.size() == 0) begin
        err_count++;
        $display("%0t: unexpected product: value=%0d index=%0d last=%0d", $time,
                 out_data.product_value, out_data.product_index, out_data.last);
      end else begin
        want = expected_products.pop_front();
        if (out_data.product_value !== want.product_value ||
            out_data.product_index !== want.product_index ||
            out_data.last !== want.last) begin
          err_count++;
          $display("%0t: expected value=%0d index=%0d last=%0d, got value=%0d index=%0d last=%0d",
                   $time, want.product_value, want.product_index, want.last,
                   out_data.product_value, out_data.product_index, out_data.last);
        end
      end
    end
  end

  // Stall the result channel in changing patterns; hold off once for a long stretch
  initial begin
    int mode, span;
    bit pressure_done;
    pressure_done = 1'b0;
    forever begin
      if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
        repeat (span) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, directed steps, random sequences, drain
  initial begin
    int sent, kind, k;
    sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[r]) begin
      repeat (DIRECTED_ROWS[r].reps)
        send_item(mk(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].coef),
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);
    end

    pressure_req <= 1'b1;
    while (sent < RANDOM_ITEMS) begin
      seq_q.delete();
      sender_quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        // well-formed operand pair and compute
        build_operands(pick_len(), pick_len(), $urandom_range(0, 3) == 0, 1'b0);
        queue_item(mk(OP_COMPUTE, rand_coef()));
      end else if (kind < 16) begin
        // compute with an empty operand
        case ($urandom_range(0, 2))
          0: build_operands(pick_len(), 0, 1'b0, 1'b0);
          1: build_operands(0, pick_len(), 1'b0, 1'b0);
          default: ;
        endcase
        queue_item(mk(OP_COMPUTE, rand_coef()));
      end else if (kind < 18) begin
        // noisy loads mixed with unused opcodes, then compute
        build_operands($urandom_range(0, 3), $urandom_range(0, 3), 1'b1, 1'b1);
        queue_item(mk(OP_UNUSED, rand_coef()));
        queue_item(mk(OP_COMPUTE, rand_coef()));
      end else begin
        // broken sequence: loads left pending for the next compute
        build_operands($urandom_range(0, 4), $urandom_range(0, 4), 1'b1, 1'b0);
      end
      for (k = 0; k < seq_q.size(); k++) begin
        send_item(seq_q[k], 1'b0, NO_EXP);
        sent++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers and %0d product transfers in %0d runs",
             in_transfers, out_transfers, runs_done);
    $display("Longest product run: %0d terms; mismatches: %0d", longest_run, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
